FILE: sv/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
package u8u16_pkg;

    // Depth of the queue between the decoder and the unit serializer
    localparam int QueueDepth = 4;
    localparam int QPtrW      = $clog2(QueueDepth);
    localparam int QCntW      = $clog2(QueueDepth + 1);

    // Units a single byte can produce: a surrogate pair plus one lead value
    localparam int MaxUnits   = 3;

    // UTF-16 surrogate constants
    localparam logic [15:0] SurrHiBase  = 16'hD800;
    localparam logic [15:0] SurrLoBase  = 16'hDC00;
    localparam logic [30:0] SuppLow     = 31'h0001_0000;
    localparam logic [30:0] SuppHigh    = 31'h0010_FFFF;
    localparam logic [9:0]  PlaneOffset = 10'h040;

    // One decoded byte: up to three code units, how many are valid, string end
    typedef struct packed {
        logic [MaxUnits-1:0][15:0] units;
        logic [1:0]                cnt;
        logic                      last;
    } unit_entry_t;

endpackage

FILE: sv/utf8_to_utf16_transcoder.sv
// Top level: UTF-8 byte stream in, UTF-16 code unit stream out.
// One byte per cycle while each byte yields at most one unit and the output is not
// stalled; the output register issues one unit per cycle while m_axis_tready is high,
// a byte yielding several units holds the serializer until its last unit is out, and the 4-entry queue absorbs bursts.
// Reset: rst_n clears decoder state, queue pointers and output valid at once.
module utf8_to_utf16_transcoder
    import u8u16_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] code_unit
    output logic        m_axis_tuser,   // last_of_run
    output logic        m_axis_tlast    // end_of_string
);

    logic        queue_full;
    logic        push;
    unit_entry_t push_entry;
    logic        pop;
    logic        not_empty;
    unit_entry_t head_entry;

    u8u16_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .byte_in    (s_axis_tdata),
        .last_byte  (s_axis_tlast),
        .in_ready   (s_axis_tready),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    u8u16_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .not_empty  (not_empty),
        .head_entry (head_entry)
    );

    u8u16_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .entry_valid   (not_empty),
        .entry         (head_entry),
        .pop           (pop),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .code_unit     (m_axis_tdata),
        .last_of_run   (m_axis_tuser),
        .end_of_string (m_axis_tlast)
    );

endmodule

FILE: sv/u8u16_front.sv
// Decoder: accepts UTF-8 bytes, tracks the open sequence and builds unit entries.
module u8u16_front
    import u8u16_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [7:0]  byte_in,
    input  logic        last_byte,
    output logic        in_ready,
    input  logic        queue_full,
    output logic        push,
    output unit_entry_t push_entry
);

    logic [2:0]  pend_cnt_reg;
    logic [2:0]  pend_cnt_next;
    logic [30:0] acc_reg;
    logic [30:0] acc_next;

    logic        accept;
    logic        is_cont;
    logic        pending;
    logic        lead_ok;
    logic [2:0]  lead_len;
    logic [6:0]  lead_pay;
    logic [30:0] acc_cont;
    logic        v0_en;
    logic [30:0] v0;
    logic        v1_en;
    logic        pair;
    logic [15:0] pay16;
    logic [1:0]  cnt;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign is_cont  = byte_in inside {[8'h80:8'hBF]};
    assign pending  = (pend_cnt_reg != 3'd0);
    assign acc_cont = {acc_reg[24:0], byte_in[5:0]};

    // Lead byte classification: payload bits and continuation count
    always_comb
    begin
        lead_ok  = 1'b1;
        lead_len = 3'd0;
        lead_pay = 7'd0;
        if (byte_in inside {[8'h00:8'h7F]})
        begin
            lead_pay = byte_in[6:0];
        end
        else if (byte_in inside {[8'hC0:8'hDF]})
        begin
            lead_len = 3'd1;
            lead_pay = {2'b00, byte_in[4:0]};
        end
        else if (byte_in inside {[8'hE0:8'hEF]})
        begin
            lead_len = 3'd2;
            lead_pay = {3'b000, byte_in[3:0]};
        end
        else if (byte_in inside {[8'hF0:8'hF7]})
        begin
            lead_len = 3'd3;
            lead_pay = {4'b0000, byte_in[2:0]};
        end
        else if (byte_in inside {[8'hF8:8'hFB]})
        begin
            lead_len = 3'd4;
            lead_pay = {5'b00000, byte_in[1:0]};
        end
        else if (byte_in inside {[8'hFC:8'hFD]})
        begin
            lead_len = 3'd5;
            lead_pay = {6'b000000, byte_in[0]};
        end
        else
        begin
            // stray continuation, 0xFE or 0xFF
            lead_ok = 1'b0;
        end
    end

    // Sequence tracking: v0 is a full-width value, v1 a freshly decoded lead
    always_comb
    begin
        pend_cnt_next = pend_cnt_reg;
        acc_next      = acc_reg;
        v0_en         = 1'b0;
        v0            = acc_reg;
        v1_en         = 1'b0;
        if (pending && is_cont)
        begin
            acc_next = acc_cont;
            v0       = acc_cont;
            if (pend_cnt_reg == 3'd1 || last_byte)
            begin
                v0_en         = 1'b1;
                pend_cnt_next = 3'd0;
            end
            else
            begin
                pend_cnt_next = pend_cnt_reg - 3'd1;
            end
        end
        else
        begin
            // an early end flushes the partial value first
            v0_en         = pending;
            pend_cnt_next = 3'd0;
            if (lead_ok)
            begin
                acc_next = {24'd0, lead_pay};
                if (lead_len == 3'd0 || last_byte)
                    v1_en = 1'b1;
                else
                    pend_cnt_next = lead_len;
            end
            else if (!pending)
            begin
                // stray byte re-emits the last value
                v0_en = 1'b1;
            end
        end
        if (last_byte)
        begin
            pend_cnt_next = 3'd0;
            acc_next      = 31'd0;
        end
    end

    // Unit packing
    assign pair  = (v0 >= SuppLow) && (v0 <= SuppHigh);
    assign pay16 = {9'd0, lead_pay};

    always_comb
    begin
        cnt = 2'd0;
        if (v0_en)
            cnt = pair ? 2'd2 : 2'd1;
        if (v1_en)
            cnt = cnt + 2'd1;
    end

    always_comb
    begin
        push_entry.units[0] = pay16;
        if (v0_en)
            push_entry.units[0] = pair ? (SurrHiBase | {6'd0, v0[19:10] - PlaneOffset})
                                       : v0[15:0];
        push_entry.units[1] = pair ? (SurrLoBase | {6'd0, v0[9:0]}) : pay16;
        push_entry.units[2] = pay16;
        push_entry.cnt      = cnt;
        push_entry.last     = last_byte;
    end

    assign push = accept && (cnt != 2'd0);

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_cnt_reg <= 3'd0;
            acc_reg      <= 31'd0;
        end
        else if (accept)
        begin
            pend_cnt_reg <= pend_cnt_next;
            acc_reg      <= acc_next;
        end
    end

    // A string end always produces at least one unit
    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_byte) |-> push)
        else $error("last byte produced no code unit");

    // State is cleared after a string end
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_byte) |=> (pend_cnt_reg == 3'd0 && acc_reg == 31'd0))
        else $error("state not cleared after string end");

endmodule

FILE: sv/u8u16_queue.sv
// Short queue of unit entries between the decoder and the serializer.
module u8u16_queue
    import u8u16_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  unit_entry_t push_entry,
    output logic        full,
    input  logic        pop,
    output logic        not_empty,
    output unit_entry_t head_entry
);

    unit_entry_t      slots [QueueDepth];
    logic [QPtrW-1:0] wr_ptr_reg;
    logic [QPtrW-1:0] rd_ptr_reg;
    logic [QCntW-1:0] count_reg;

    assign full       = (count_reg == QCntW'(QueueDepth));
    assign not_empty  = (count_reg != '0);
    assign head_entry = slots[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_entry;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPtrW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPtrW'(1);
            if (push && !pop)
                count_reg <= count_reg + QCntW'(1);
            else if (pop && !push)
                count_reg <= count_reg - QCntW'(1);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");

endmodule

FILE: sv/u8u16_back.sv
// Serializer: walks the units of each entry and drives the output register.
module u8u16_back
    import u8u16_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        entry_valid,
    input  unit_entry_t entry,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] code_unit,
    output logic        last_of_run,
    output logic        end_of_string
);

    unit_entry_t cur_reg;
    logic        cur_valid_reg;
    logic [1:0]  idx_reg;
    logic        out_valid_reg;
    logic [15:0] out_unit_reg;
    logic        out_run_reg;
    logic        out_eos_reg;

    logic        advance;
    logic        final_unit;
    logic [15:0] sel_unit;

    assign advance    = cur_valid_reg && (!out_valid_reg || out_ready);
    assign final_unit = (idx_reg == cur_reg.cnt - 2'd1);
    assign pop        = entry_valid && (!cur_valid_reg || (advance && final_unit));

    // Unit select
    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_unit = cur_reg.units[0];
            2'd1:    sel_unit = cur_reg.units[1];
            2'd2:    sel_unit = cur_reg.units[2];
            default: sel_unit = cur_reg.units[0];
        endcase
    end

    // Current entry
    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else if (pop)
        begin
            cur_valid_reg <= 1'b1;
            idx_reg       <= 2'd0;
        end
        else if (advance && final_unit)
        begin
            cur_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_unit_reg <= sel_unit;
            out_run_reg  <= final_unit;
            out_eos_reg  <= final_unit && cur_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid     = out_valid_reg;
    assign code_unit     = out_unit_reg;
    assign last_of_run   = out_run_reg;
    assign end_of_string = out_eos_reg;

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (cur_reg.cnt != 2'd0 && idx_reg < cur_reg.cnt))
        else $error("unit index beyond entry");

    a_eos_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_eos_reg) |-> out_run_reg)
        else $error("string end on a unit that is not last of its run");

endmodule

FILE: tb/utf16_unit_checker.sv
// Checker for the UTF-8 to UTF-16 transcoder: predicts code units and compares them.
module utf16_unit_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] byte_in
    input  logic        s_tlast,    // last_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,    // [15:0] code_unit
    input  logic        m_tuser,    // last_of_run
    input  logic        m_tlast,    // end_of_string
    output int          fail_count,
    output int          units_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] code;
        logic        run_end;
        logic        str_end;
    } utf16_unit_t;

    utf16_unit_t expected_units[$];

    // Decoder state: continuation bytes still owed and the value being built
    logic [2:0]  cont_left;
    logic [30:0] code_acc;

    // Units produced by the byte being predicted
    logic [15:0] step_units[4];
    int          step_n;

    // Queue one value as a single unit or a surrogate pair
    task automatic emit_value(input logic [30:0] v);
        logic [9:0] hi;
        if (v >= 31'h0001_0000 && v <= 31'h0010_FFFF)
        begin
            hi = 10'(v[20:10] - 11'h040);
            step_units[step_n] = 16'hD800 | {6'b0, hi};
            step_n++;
            step_units[step_n] = 16'hDC00 | {6'b0, v[9:0]};
            step_n++;
        end
        else
        begin
            step_units[step_n] = v[15:0];
            step_n++;
        end
    endtask

    // Treat b as the start of a new sequence; flushed means a partial value just went out
    task automatic start_sequence(input logic [7:0] b, input logic lst, input logic flushed);
        logic [2:0] len;
        logic       is_lead;
        is_lead = 1'b1;
        len     = 3'd0;
        if (b inside {[8'h00:8'h7F]})
        begin
            code_acc = {24'b0, b[6:0]};
            len      = 3'd0;
        end
        else if (b inside {[8'hC0:8'hDF]})
        begin
            code_acc = {26'b0, b[4:0]};
            len      = 3'd1;
        end
        else if (b inside {[8'hE0:8'hEF]})
        begin
            code_acc = {27'b0, b[3:0]};
            len      = 3'd2;
        end
        else if (b inside {[8'hF0:8'hF7]})
        begin
            code_acc = {28'b0, b[2:0]};
            len      = 3'd3;
        end
        else if (b inside {[8'hF8:8'hFB]})
        begin
            code_acc = {29'b0, b[1:0]};
            len      = 3'd4;
        end
        else if (b inside {[8'hFC:8'hFD]})
        begin
            code_acc = {30'b0, b[0]};
            len      = 3'd5;
        end
        else
        begin
            is_lead = 1'b0;
        end
        if (!is_lead)
        begin
            // stray continuation, 0xFE or 0xFF: repeat the last value once
            if (!flushed)
                emit_value(code_acc);
        end
        else if (len == 3'd0 || lst)
            emit_value(code_acc);
        else
            cont_left = len;
    endtask

    // Predict the units caused by one accepted byte and queue them
    task automatic decode_utf8_byte(input logic [7:0] b, input logic lst);
        utf16_unit_t u;
        step_n = 0;
        if (cont_left != 3'd0 && b[7:6] == 2'b10)
        begin
            code_acc  = {code_acc[24:0], b[5:0]};
            cont_left = cont_left - 3'd1;
            if (cont_left == 3'd0 || lst)
            begin
                emit_value(code_acc);
                cont_left = 3'd0;
            end
        end
        else if (cont_left != 3'd0)
        begin
            // early end of a sequence: flush the partial value first
            emit_value(code_acc);
            cont_left = 3'd0;
            start_sequence(b, lst, 1'b1);
        end
        else
            start_sequence(b, lst, 1'b0);

        for (int k = 0; k < step_n; k++)
        begin
            u.code    = step_units[k];
            u.run_end = (k == step_n - 1);
            u.str_end = (k == step_n - 1) && lst;
            expected_units.push_back(u);
        end
        if (lst)
        begin
            cont_left = 3'd0;
            code_acc  = 31'd0;
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        fail_count++;
    endtask

    // Watch both channels: predict on input transactions, compare on output ones
    always @(posedge clk or negedge rst_n)
    begin
        utf16_unit_t want;
        if (!rst_n)
        begin
            cont_left = 3'd0;
            code_acc  = 31'd0;
            expected_units.delete();
            units_waiting = 0;
            fail_count    = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                decode_utf8_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                if (expected_units.size() == 0)
                    report_mismatch($sformatf("unexpected unit %h", m_tdata));
                else
                begin
                    want = expected_units.pop_front();
                    if (m_tdata !== want.code)
                        report_mismatch($sformatf("code_unit %h, want %h", m_tdata, want.code));
                    if (m_tuser !== want.run_end)
                        report_mismatch($sformatf("last_of_run %b, want %b on unit %h",
                                                  m_tuser, want.run_end, want.code));
                    if (m_tlast !== want.str_end)
                        report_mismatch($sformatf("end_of_string %b, want %b on unit %h",
                                                  m_tlast, want.str_end, want.code));
                end
            end
            units_waiting = expected_units.size();
        end
    end

endmodule

FILE: tb/testbench.sv
// Top of the transcoder testbench: clock, reset, byte stimulus, output stalls and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RandomBytes = 225;
    localparam int StallLimit  = 1000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    int          fail_count;
    int          units_waiting;
    int          quiet_cycles = 0;
    logic        calm = 1'b0;

    // Directed bytes, {last_byte, byte_in}
    logic [8:0] directed_bytes [0:26] = '{
        9'h000, 9'h07F,                         // ASCII extremes
        9'h0C3, 9'h0A9,                         // two-byte form
        9'h0E2, 9'h082, 9'h0AC,                 // three-byte form
        9'h0F0, 9'h09F, 9'h098, 9'h080,         // four-byte form, surrogate pair
        9'h080, 9'h0FE,                         // stray continuation, invalid byte
        9'h0E2, 9'h0FF,                         // invalid byte ends a sequence
        9'h0E2, 9'h041,                         // lead byte ends a sequence early
        9'h0F4, 9'h18F,                         // string ends with a sequence open
        9'h1C3,                                 // string ends on a lead byte
        9'h0FD, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF, // six-byte form, widest value
        9'h1FF                                  // string end on an invalid byte
    };

    utf8_to_utf16_transcoder uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tlast  (s_tlast),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .m_axis_tlast  (m_tlast)
    );

    utf16_unit_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .units_waiting (units_waiting)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Output side stalls at random except during the calm stretch
    always @(negedge clk)
        m_tready <= calm || ($urandom_range(99) >= 28);

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= StallLimit)
            begin
                $display("testbench NOT OK");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one byte, with random idle cycles ahead of it, and wait for its transaction
    task automatic send_byte(input logic [7:0] b, input logic lst);
        while (!calm && $urandom_range(99) < 28)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            s_tlast  <= 1'($urandom);
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Hold the input off until every predicted unit has come out
    task automatic drain_units();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (units_waiting != 0)
            @(negedge clk);
    endtask

    function automatic logic [7:0] lead_byte(input int len);
        logic [31:0] r;
        r = $urandom;
        case (len)
            1:       lead_byte = {1'b0, r[6:0]};
            2:       lead_byte = {3'b110, r[4:0]};
            3:       lead_byte = {4'b1110, r[3:0]};
            4:       lead_byte = {5'b11110, r[2:0]};
            5:       lead_byte = {6'b111110, r[1:0]};
            default: lead_byte = {7'b1111110, r[0]};
        endcase
    endfunction

    initial
    begin
        int          sent;
        int          len;
        int          cut;
        int          pick;
        logic        ends;
        logic        pressure_done;
        logic [31:0] r;

        sent          = 0;
        pressure_done = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part
        for (int i = 0; i < 27; i++)
            send_byte(directed_bytes[i][7:0], directed_bytes[i][8]);
        drain_units();

        // Random part: mostly well-formed sequences, some noise and cut-off sequences
        while (sent < RandomBytes)
        begin
            calm = (sent >= 120 && sent < 180);
            if ($urandom_range(99) < 80)
            begin
                pick = $urandom_range(99);
                len  = pick < 35 ? 1 : pick < 55 ? 2 : pick < 75 ? 3 :
                       pick < 88 ? 4 : pick < 94 ? 5 : 6;
                cut  = ($urandom_range(99) < 10) ? $urandom_range(1, len) : len;
                ends = ($urandom_range(99) < 15);
                for (int k = 0; k < cut; k++)
                begin
                    r = $urandom;
                    send_byte(k == 0 ? lead_byte(len) : {2'b10, r[5:0]},
                              ends && (k == cut - 1));
                    sent++;
                end
            end
            else
            begin
                r = $urandom;
                send_byte(r[7:0], $urandom_range(99) < 10);
                sent++;
            end
            if (!pressure_done && sent >= 200)
            begin
                drain_units();
                pressure_done = 1'b1;
            end
        end
        calm = 1'b0;

        // Let the queue empty, then wait for anything stray before the verdict
        drain_units();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
